/* sv/lms_eq_pkg.sv */
package lms_eq_pkg;

    localparam int DefaultNumTaps = 256;
    localparam int SampleW        = 16;
    localparam int TapW           = 24;
    localparam int StepW          = 16;
    localparam int ErrW           = 17;
    localparam logic [StepW-1:0] StepReset = 16'd13422;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_OUT,
        ST_UPD
    } eq_state_t;

    // control from sequencer to datapath
    typedef struct packed {
        logic acc_clear;
        logic acc_en;
        logic out_load;
        logic err_load;
        logic upd_en;
    } eq_ctrl_t;

endpackage

/* sv/lms_adaptive_fir_equalizer.sv */
// LMS adaptive FIR equalizer. Each sample transfer shifts into a NUM_TAPS deep
// window and produces one saturated Q7.8 output, the window dot taps, rounded
// from Q18.29. With train high the taps (Q2.21, saturating) are then adapted by
// tap -= step_size*(filtered-ideal)*sample/2^23. Window and taps sit in two
// single-port-read memories swept one tap per cycle, by a multiply-accumulate
// for the output and by a separate multiplier for the tap update. A new sample
// is taken only once the previous item's pass is done, and a training item
// adds a tap sweep. A stalled output holds the sequencer until it is taken.
// After reset a clearing pass zeroes both memories before the first sample is
// taken.
module lms_adaptive_fir_equalizer #(
    parameter int NUM_TAPS = lms_eq_pkg::DefaultNumTaps
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lms_eq_pkg::StepW-1:0]    cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [lms_eq_pkg::SampleW-1:0] sample,
    input  logic                            train,
    input  logic signed [lms_eq_pkg::SampleW-1:0] ideal,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [lms_eq_pkg::SampleW-1:0] filtered
);

    localparam int AddrW = $clog2(NUM_TAPS);
    localparam int SW    = lms_eq_pkg::SampleW;
    localparam int TW    = lms_eq_pkg::TapW;
    localparam int AccW  = TW + SW + AddrW;
    localparam int PW    = lms_eq_pkg::StepW + lms_eq_pkg::ErrW + 1;

    logic [lms_eq_pkg::StepW-1:0] step_reg;
    logic                 ready, in_xfer, is_train;
    logic [AddrW-1:0]     idx;
    lms_eq_pkg::eq_ctrl_t ctrl;
    logic                 clearing;

    assign in_stall = !ready;
    assign in_xfer  = in_valid && ready;

    // step size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= lms_eq_pkg::StepReset;
        end
        else if (cfg_we)
        begin
            step_reg <= cfg_wdata;
        end
    end

    lms_eq_ctrl #(.NumTaps(NUM_TAPS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_xfer(in_xfer), .train(train),
        .out_busy(out_valid && out_stall), .ready(ready), .clearing(clearing),
        .idx(idx), .is_train(is_train), .ctrl(ctrl)
    );

    // window is a circular buffer; head points at the oldest entry
    logic [AddrW-1:0] head_reg;
    logic [AddrW-1:0] wpos;
    logic [AddrW:0]   rsum;
    logic [AddrW-1:0] win_raddr, win_waddr, tap_waddr;
    logic             win_we, tap_we;
    logic [SW-1:0]    win_wdata, win_rdata;
    logic [TW-1:0]    tap_wdata, tap_rdata;
    logic [AddrW-1:0] idx_d_reg;

    // modular add of head and tap index
    always_comb
    begin
        rsum = {1'b0, head_reg} + {1'b0, idx};
        if (rsum >= (AddrW+1)'(NUM_TAPS))
        begin
            rsum = rsum - (AddrW+1)'(NUM_TAPS);
        end
        win_raddr = rsum[AddrW-1:0];
    end

    // new sample overwrites the oldest, then head advances
    assign wpos      = head_reg;
    assign win_we    = clearing || in_xfer;
    assign win_waddr = clearing ? idx : wpos;
    assign win_wdata = clearing ? '0 : sample;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
        end
        else if (in_xfer)
        begin
            if (head_reg == AddrW'(NUM_TAPS - 1))
            begin
                head_reg <= '0;
            end
            else
            begin
                head_reg <= head_reg + 1'b1;
            end
        end
    end

    lms_eq_mem #(.Depth(NUM_TAPS), .Width(SW)) u_win (
        .clk(clk), .we(win_we), .waddr(win_waddr), .wdata(win_wdata),
        .raddr(win_raddr), .rdata(win_rdata)
    );

    lms_eq_mem #(.Depth(NUM_TAPS), .Width(TW)) u_tap (
        .clk(clk), .we(tap_we), .waddr(tap_waddr), .wdata(tap_wdata),
        .raddr(idx), .rdata(tap_rdata)
    );

    always_ff @(posedge clk)
    begin
        idx_d_reg <= idx;
    end

    // multiply-accumulate for the output
    logic signed [AccW-1:0]  acc_reg;
    logic signed [TW+SW-1:0] prod;
    logic signed [AccW-1:0]  rnd;
    logic signed [AccW-1:0]  shifted;
    logic signed [SW-1:0]    y;

    assign prod = $signed(tap_rdata) * $signed(win_rdata);

    always_ff @(posedge clk)
    begin
        if (ctrl.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_reg + AccW'(prod);
        end
    end

    always_comb
    begin
        rnd     = acc_reg + AccW'(1 << 20);
        shifted = rnd >>> 21;
        if (shifted > AccW'(32767))
        begin
            y = 16'sh7fff;
        end
        else if (shifted < -AccW'(32768))
        begin
            y = -16'sh8000;
        end
        else
        begin
            y = shifted[SW-1:0];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            filtered <= y;
        end
    end

    // error times step, formed once per training item
    logic signed [SW-1:0]               ideal_reg;
    logic signed [lms_eq_pkg::ErrW-1:0] err;
    logic signed [PW-1:0]               ke_reg;

    assign err = lms_eq_pkg::ErrW'(y) - lms_eq_pkg::ErrW'(ideal_reg);

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            ideal_reg <= ideal;
        end
        if (ctrl.err_load && is_train)
        begin
            ke_reg <= $signed({1'b0, step_reg}) * err;
        end
    end

    // tap update: read-modify-write one tap per cycle
    localparam int DW = PW + SW;
    logic signed [DW-1:0] dprod;
    logic signed [DW-1:0] delta;
    logic signed [DW-1:0] tnew;

    assign dprod = ke_reg * $signed(win_rdata);

    always_comb
    begin
        delta = (dprod + DW'(1 << 22)) >>> 23;
        tnew  = DW'($signed(tap_rdata)) - delta;
        if (clearing)
        begin
            tap_wdata = '0;
        end
        else if (tnew > DW'(8388607))
        begin
            tap_wdata = 24'h7fffff;
        end
        else if (tnew < -DW'(8388608))
        begin
            tap_wdata = 24'h800000;
        end
        else
        begin
            tap_wdata = tnew[TW-1:0];
        end
    end

    assign tap_we    = clearing || ctrl.upd_en;
    assign tap_waddr = clearing ? idx : idx_d_reg;

endmodule

/* sv/lms_eq_mem.sv */
module lms_eq_mem #(
    parameter int Depth = lms_eq_pkg::DefaultNumTaps,
    parameter int Width = lms_eq_pkg::TapW,
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [Width-1:0] wdata,
    input  logic [AddrW-1:0] raddr,
    output logic [Width-1:0] rdata
);

    logic [Width-1:0] mem [Depth];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/lms_eq_ctrl.sv */
module lms_eq_ctrl #(
    parameter int NumTaps = lms_eq_pkg::DefaultNumTaps,
    localparam int AddrW = $clog2(NumTaps)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_xfer,
    input  logic                  train,
    input  logic                  out_busy,
    output logic                  ready,
    output logic                  clearing,
    output logic [AddrW-1:0]      idx,
    output logic                  is_train,
    output lms_eq_pkg::eq_ctrl_t  ctrl
);

    lms_eq_pkg::eq_state_t state_reg, state_next;
    logic [AddrW-1:0] cnt_reg, cnt_next;
    logic             vld_reg, vld_next;
    logic             vld_d_reg;
    logic             train_reg, train_next;
    logic             last;

    assign last = (cnt_reg == AddrW'(NumTaps - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        vld_next   = 1'b0;
        train_next = train_reg;
        case (state_reg)
            lms_eq_pkg::ST_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last)
                begin
                    state_next = lms_eq_pkg::ST_IDLE;
                end
            end
            lms_eq_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (in_xfer)
                begin
                    train_next = train;
                    vld_next   = 1'b1;
                    state_next = lms_eq_pkg::ST_MAC;
                end
            end
            lms_eq_pkg::ST_MAC:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last)
                begin
                    state_next = lms_eq_pkg::ST_OUT;
                end
                else
                begin
                    vld_next = 1'b1;
                end
            end
            lms_eq_pkg::ST_OUT:
            begin
                // wait for the last product to land and the output slot to free
                if (!out_busy && !vld_d_reg)
                begin
                    cnt_next = '0;
                    if (train_reg)
                    begin
                        vld_next   = 1'b1;
                        state_next = lms_eq_pkg::ST_UPD;
                    end
                    else
                    begin
                        state_next = lms_eq_pkg::ST_IDLE;
                    end
                end
            end
            lms_eq_pkg::ST_UPD:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last)
                begin
                    state_next = lms_eq_pkg::ST_IDLE;
                end
                else
                begin
                    vld_next = 1'b1;
                end
            end
            default:
            begin
                state_next = lms_eq_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs; read data is registered, so it arrives in the cycle after its address
    always_comb
    begin
        ready          = (state_reg == lms_eq_pkg::ST_IDLE);
        clearing       = (state_reg == lms_eq_pkg::ST_CLEAR);
        ctrl.acc_clear = in_xfer && (state_reg == lms_eq_pkg::ST_IDLE);
        ctrl.acc_en    = vld_d_reg && (state_reg == lms_eq_pkg::ST_MAC
                                       || state_reg == lms_eq_pkg::ST_OUT);
        ctrl.out_load  = (state_reg == lms_eq_pkg::ST_OUT) && !out_busy && !vld_d_reg;
        ctrl.err_load  = ctrl.out_load;
        ctrl.upd_en    = vld_d_reg && (state_reg == lms_eq_pkg::ST_UPD
                                       || state_reg == lms_eq_pkg::ST_IDLE);
    end

    assign idx       = cnt_reg;
    assign is_train  = train_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lms_eq_pkg::ST_CLEAR;
            cnt_reg   <= '0;
            vld_reg   <= 1'b0;
            vld_d_reg <= 1'b0;
            train_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            vld_reg   <= vld_next;
            vld_d_reg <= vld_reg;
            train_reg <= train_next;
        end
    end

endmodule

/* tb/sv/tb_top.sv */
module tb_top;

    localparam int NTaps = 256;
    localparam int ItemCycles = 2 * NTaps + 8;
    localparam longint CycleLimit = 64'd6000000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [lms_eq_pkg::StepW-1:0] cfg_wdata;
    logic in_valid;
    logic in_stall;
    logic signed [lms_eq_pkg::SampleW-1:0] sample;
    logic train;
    logic signed [lms_eq_pkg::SampleW-1:0] ideal;
    logic out_valid;
    logic out_stall;
    logic signed [lms_eq_pkg::SampleW-1:0] filtered;

    lms_adaptive_fir_equalizer #(.NUM_TAPS(NTaps)) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample(sample),
        .train(train),
        .ideal(ideal),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .filtered(filtered)
    );

    // equalizer shadow state
    logic [lms_eq_pkg::StepW-1:0] mu_code;
    logic signed [lms_eq_pkg::SampleW-1:0] win_q [NTaps];
    logic signed [lms_eq_pkg::TapW-1:0] tap_q [NTaps];
    logic signed [lms_eq_pkg::SampleW-1:0] expected_out [$];

    int errors;
    longint cycle_count;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("lms_adaptive_fir_equalizer regression: fail");
            $finish;
        end
    end

    function automatic logic signed [lms_eq_pkg::SampleW-1:0] equalize(
        logic signed [lms_eq_pkg::SampleW-1:0] s, logic trn,
        logic signed [lms_eq_pkg::SampleW-1:0] want);
        longint acc;
        longint y;
        longint err;
        longint prod;
        longint t;
        acc = 0;
        for (int i = 0; i < NTaps - 1; i++)
        begin
            win_q[i] = win_q[i+1];
        end
        win_q[NTaps-1] = s;
        for (int i = 0; i < NTaps; i++)
        begin
            acc += longint'(tap_q[i]) * longint'(win_q[i]);
        end
        y = (acc + (64'sd1 <<< 20)) >>> 21;
        if (y > 32767)
        begin
            y = 32767;
        end
        else if (y < -32768)
        begin
            y = -32768;
        end
        if (trn)
        begin
            err = y - longint'(want);
            for (int i = 0; i < NTaps; i++)
            begin
                prod = longint'({1'b0, mu_code}) * err * longint'(win_q[i]);
                t = longint'(tap_q[i]) - ((prod + (64'sd1 <<< 22)) >>> 23);
                if (t > 8388607)
                begin
                    t = 8388607;
                end
                else if (t < -8388608)
                begin
                    t = -8388608;
                end
                tap_q[i] = t[lms_eq_pkg::TapW-1:0];
            end
        end
        return y[lms_eq_pkg::SampleW-1:0];
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // receiver side: stall control
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // result check on each output transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_out.size() == 0)
            begin
                report("unexpected output", filtered, 0);
            end
            else
            begin
                if (filtered !== expected_out[0])
                begin
                    report("filtered", filtered, expected_out[0]);
                end
                void'(expected_out.pop_front());
            end
        end
    end

    // valid stays up after a transfer until the next item or an idle cycle
    task automatic send_sample(logic signed [lms_eq_pkg::SampleW-1:0] s, logic trn,
                               logic signed [lms_eq_pkg::SampleW-1:0] want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        sample <= s;
        train <= trn;
        ideal <= want;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        expected_out.push_back(equalize(s, trn, want));
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_out.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (ItemCycles) @(negedge clk);
    endtask

    task automatic write_step(logic [lms_eq_pkg::StepW-1:0] v);
        drain();
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        mu_code = v;
    endtask

    // training symbols are the usual eight-level constellation
    function automatic logic signed [lms_eq_pkg::SampleW-1:0] symbol_level();
        int lv;
        lv = 2 * $urandom_range(7) - 7;
        return lms_eq_pkg::SampleW'(lv * 256);
    endfunction

    task automatic test_directed_extremes();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_sample(16'sh7fff, 1'b0, 16'sh0000);
        send_sample(-16'sh8000, 1'b0, 16'sh7fff);
        send_sample(16'sh0000, 1'b1, 16'sh7fff);
        send_sample(16'sh7fff, 1'b1, -16'sh8000);
        send_sample(-16'sh8000, 1'b1, 16'sh7fff);
        send_sample(16'sh0100, 1'b1, -16'sh8000);
        send_sample(16'sh5555, 1'b0, -16'sh5556);
        send_sample(-16'sh5556, 1'b1, 16'sh5555);
        send_sample(16'sh0001, 1'b1, 16'sh0000);
        send_sample(-16'sh0001, 1'b0, -16'sh0001);
    endtask

    // largest gain drives taps into saturation
    task automatic test_tap_saturation();
        write_step(16'hffff);
        for (int i = 0; i < 12; i++)
        begin
            send_sample((i % 2) ? 16'sh7fff : -16'sh8000, 1'b1,
                        (i % 2) ? -16'sh8000 : 16'sh7fff);
        end
        write_step(16'h0000);
        send_sample(16'sh1234, 1'b1, -16'sh4321);
        send_sample(16'sh7fff, 1'b0, 16'sh0000);
    endtask

    task automatic random_phase(int n, int idle_pct, int stall_pct);
        logic signed [lms_eq_pkg::SampleW-1:0] s;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) < 7)
            begin
                s = symbol_level() + lms_eq_pkg::SampleW'($urandom_range(255) - 128);
                send_sample(s, $urandom_range(3) != 0, symbol_level());
            end
            else
            begin
                send_sample(lms_eq_pkg::SampleW'($urandom), 1'($urandom_range(1)),
                            lms_eq_pkg::SampleW'($urandom));
            end
        end
    endtask

    task automatic test_random_training();
        write_step(16'd13422);
        random_phase(380, 0, 0);
        write_step(16'd40000);
        random_phase(380, 78, 0);
        write_step(lms_eq_pkg::StepW'($urandom_range(65535)));
        random_phase(380, 0, 78);
        write_step(16'd1);
        random_phase(360, 8, 8);
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        write_step(16'd13422);
        hold_cycles = 4 * ItemCycles;
        random_phase(30, 0, 0);
    endtask

    initial
    begin
        errors = 0;
        cycle_count = 0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        sample = '0;
        train = 1'b0;
        ideal = '0;
        out_stall = 1'b0;
        mu_code = lms_eq_pkg::StepReset;
        for (int i = 0; i < NTaps; i++)
        begin
            win_q[i] = '0;
            tap_q[i] = '0;
        end
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_directed_extremes();
        test_tap_saturation();
        test_random_training();
        test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        if (errors == 0)
        begin
            $display("lms_adaptive_fir_equalizer regression: pass");
        end
        else
        begin
            $display("lms_adaptive_fir_equalizer regression: fail");
        end
        $finish;
    end
endmodule
